/* rtl/ttsp_pkg.sv */
package ttsp_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_STORE      = 2'd1,
    OP_NEW_SEARCH = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  localparam int unsigned AGE_W = 8;
  localparam logic [AGE_W-1:0] AGE_FIRST = 8'd1;
  localparam logic signed [15:0] EVAL_NONE = 16'sh8000;
  localparam logic signed [15:0] INT16_TOP = 16'sh7fff;

  // One table slot as held in the RAM
  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] eval;
    logic [15:0]        move;
    logic signed [15:0] depth;
    logic signed [15:0] score;
    logic [AGE_W-1:0]   age;
    logic [1:0]         kind;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Input word as captured on accept
  typedef struct packed {
    op_e                op;
    logic [63:0]        key;
    logic signed [15:0] depth;
    logic signed [15:0] score;
    logic [1:0]         node_kind;
    logic [15:0]        move;
    logic signed [15:0] eval;
  } item_t;

  // Result word
  typedef struct packed {
    logic               hit;
    logic               written;
    logic signed [15:0] score;
    logic signed [15:0] depth;
    logic signed [15:0] eval;
    logic [15:0]        move;
    logic [1:0]         kind;
    logic [AGE_W-1:0]   age;
  } res_t;

endpackage

/* rtl/transposition_table_store_probe_unit.sv */
// Direct-mapped transposition table of 2^INDEX_BITS slots held in one RAM,
// indexed by the low key bits. Each word goes through a slot read and then
// the decision and write-back, and the next word is accepted once the previous
// result has been taken, so a new word is taken only after the last one is
// through. After reset, and after a clear-table word, the block sweeps the
// RAM one slot a cycle and holds in_stall_o high until every slot is cleared.
// Every word gives exactly one result word.
module transposition_table_store_probe_unit import ttsp_pkg::*; #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [63:0]        key_i,
  input  logic signed [15:0] depth_i,
  input  logic signed [15:0] score_i,
  input  logic [1:0]         node_kind_i,
  input  logic [15:0]        move_i,
  input  logic signed [15:0] eval_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic               written_o,
  output logic signed [15:0] found_score_o,
  output logic signed [15:0] found_depth_o,
  output logic signed [15:0] found_eval_o,
  output logic [15:0]        found_move_o,
  output logic [1:0]         found_kind_o,
  output logic [AGE_W-1:0]   found_age_o
);

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [INDEX_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic [AGE_W-1:0]      age_q, age_d;
  logic                  out_valid_q, out_valid_d;
  item_t                 item_q;
  res_t                  res_q;

  logic                  in_accept;
  item_t                 item_in;
  slot_t                 rd_slot;
  logic [SLOT_W-1:0]     rd_data;
  res_t                  res;
  logic                  st_we;
  slot_t                 st_slot;
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [SLOT_W-1:0]     ram_wdata;

  // input side
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    item_in.op        = op_e'(op_i);
    item_in.key       = key_i;
    item_in.depth     = depth_i;
    item_in.score     = score_i;
    item_in.node_kind = node_kind_i;
    item_in.move      = move_i;
    item_in.eval      = eval_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= item_in;
    end
  end

  // slot RAM: read on accept, write on store or during the sweep
  assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_EXEC) && st_we);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : item_q.key[INDEX_BITS-1:0];
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : st_slot;

  ttsp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (key_i[INDEX_BITS-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_slot = slot_t'(rd_data);

  ttsp_slot_logic u_slot_logic (
    .item_i    (item_q),
    .slot_i    (rd_slot),
    .cur_age_i (age_q),
    .res_o     (res),
    .we_o      (st_we),
    .wslot_o   (st_slot)
  );

  // control
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    age_d       = age_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
        if (item_q.op == OP_NEW_SEARCH) begin
          // generation skips zero on wrap
          age_d = (&age_q) ? AGE_FIRST : age_q + 1'b1;
        end else if (item_q.op == OP_CLEAR) begin
          age_d     = AGE_FIRST;
          clr_cnt_d = '0;
          state_d   = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      age_q       <= AGE_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      age_q       <= age_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = res_q.hit;
  assign written_o     = res_q.written;
  assign found_score_o = res_q.score;
  assign found_depth_o = res_q.depth;
  assign found_eval_o  = res_q.eval;
  assign found_move_o  = res_q.move;
  assign found_kind_o  = res_q.kind;
  assign found_age_o   = res_q.age;

endmodule

/* rtl/ttsp_ram.sv */
module ttsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/ttsp_slot_logic.sv */
module ttsp_slot_logic import ttsp_pkg::*; (
  input  item_t            item_i,
  input  slot_t            slot_i,
  input  logic [AGE_W-1:0] cur_age_i,
  output res_t             res_o,
  output logic             we_o,
  output slot_t            wslot_o
);

  logic               key_match;
  logic               replace;
  logic               keep_eval;
  logic signed [15:0] new_eval;

  assign key_match = (slot_i.key == item_i.key);

  // replace on an older generation or a depth at least as deep
  assign replace = (slot_i.age != cur_age_i) || (item_i.depth >= slot_i.depth);

  // eval none keeps the old eval only for a written slot of the same key;
  // any other value is already within -INT16_TOP..INT16_TOP
  assign keep_eval = (slot_i.age != '0) && key_match;

  always_comb begin
    if (item_i.eval == EVAL_NONE) begin
      new_eval = keep_eval ? slot_i.eval : EVAL_NONE;
    end else if (item_i.eval > INT16_TOP) begin
      new_eval = INT16_TOP;
    end else begin
      new_eval = item_i.eval;
    end
  end

  // new slot contents
  always_comb begin
    wslot_o.key   = item_i.key;
    wslot_o.eval  = new_eval;
    wslot_o.move  = item_i.move;
    wslot_o.depth = item_i.depth;
    wslot_o.score = item_i.score;
    wslot_o.age   = cur_age_i;
    wslot_o.kind  = item_i.node_kind;
  end

  // result word
  always_comb begin
    res_o = '0;
    we_o  = 1'b0;
    unique case (item_i.op)
      OP_PROBE: begin
        if (key_match) begin
          res_o.hit   = 1'b1;
          res_o.score = slot_i.score;
          res_o.depth = slot_i.depth;
          res_o.eval  = slot_i.eval;
          res_o.move  = slot_i.move;
          res_o.kind  = slot_i.kind;
          res_o.age   = slot_i.age;
        end
      end
      OP_STORE: begin
        we_o          = replace;
        res_o.written = replace;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

/* bench/transposition_table_store_probe_unit_test.sv */
module transposition_table_store_probe_unit_test;
  import ttsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_BITS   = 10;
  localparam int SLOT_COUNT   = 1 << INDEX_BITS;
  localparam int KEY_POOL     = 38;
  localparam int RANDOM_WORDS = 1070;
  localparam int WRAP_RUN     = 260;
  localparam int PRINT_CAP    = 100;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_PROBE;
  logic [63:0]        key_i = '0;
  logic signed [15:0] depth_i = '0;
  logic signed [15:0] score_i = '0;
  logic [1:0]         node_kind_i = '0;
  logic [15:0]        move_i = '0;
  logic signed [15:0] eval_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic               written_o;
  logic signed [15:0] found_score_o;
  logic signed [15:0] found_depth_o;
  logic signed [15:0] found_eval_o;
  logic [15:0]        found_move_o;
  logic [1:0]         found_kind_o;
  logic [AGE_W-1:0]   found_age_o;

  // no idling on either side while set
  bit          calm = 1'b0;
  logic [63:0] key_pool [KEY_POOL];

  // Slot table shadow plus the queue of result words it predicts
  class tt_scoreboard;
    slot_t            slots [SLOT_COUNT];
    logic [AGE_W-1:0] age_now;
    res_t             expected_results [$];
    int               mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      foreach (slots[i]) slots[i] = '0;
      age_now = AGE_FIRST;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Update the shadow table for an accepted word and queue its result
    function void note_word(item_t w);
      res_t                    r;
      slot_t                   s;
      logic [INDEX_BITS-1:0]   idx;
      logic signed [15:0]      new_eval;
      r   = '0;
      idx = w.key[INDEX_BITS-1:0];
      s   = slots[idx];
      case (w.op)
        OP_PROBE: begin
          if (s.key == w.key) begin
            r.hit   = 1'b1;
            r.score = s.score;
            r.depth = s.depth;
            r.eval  = s.eval;
            r.move  = s.move;
            r.kind  = s.kind;
            r.age   = s.age;
          end
        end
        OP_STORE: begin
          // eval none keeps the old eval only on a live slot with the same key;
          // clamping to +-INT16_TOP leaves every other 16-bit value alone
          if (w.eval == EVAL_NONE) begin
            new_eval = (s.age != '0 && s.key == w.key) ? s.eval : EVAL_NONE;
          end else begin
            new_eval = w.eval;
          end
          if (s.age != age_now || $signed(w.depth) >= $signed(s.depth)) begin
            s.key       = w.key;
            s.eval      = new_eval;
            s.move      = w.move;
            s.depth     = w.depth;
            s.score     = w.score;
            s.age       = age_now;
            s.kind      = w.node_kind;
            slots[idx]  = s;
            r.written   = 1'b1;
          end
        end
        OP_NEW_SEARCH: begin
          age_now = age_now + 1'b1;
          if (age_now == '0) age_now = AGE_FIRST;
        end
        default: wipe();
      endcase
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < PRINT_CAP) begin
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      end
      mismatches++;
    endtask

    task check_word(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding", 64'(got.hit), '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
      if (got.written !== want.written)
        report_mismatch("written", 64'(got.written), 64'(want.written));
      if (got.score !== want.score)
        report_mismatch("found_score", 64'(got.score), 64'(want.score));
      if (got.depth !== want.depth)
        report_mismatch("found_depth", 64'(got.depth), 64'(want.depth));
      if (got.eval !== want.eval)
        report_mismatch("found_eval", 64'(got.eval), 64'(want.eval));
      if (got.move !== want.move)
        report_mismatch("found_move", 64'(got.move), 64'(want.move));
      if (got.kind !== want.kind)
        report_mismatch("found_kind", 64'(got.kind), 64'(want.kind));
      if (got.age !== want.age)
        report_mismatch("found_age", 64'(got.age), 64'(want.age));
    endtask
  endclass

  tt_scoreboard sb = new();

  transposition_table_store_probe_unit #(
    .INDEX_BITS(INDEX_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .key_i        (key_i),
    .depth_i      (depth_i),
    .score_i      (score_i),
    .node_kind_i  (node_kind_i),
    .move_i       (move_i),
    .eval_i       (eval_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .written_o    (written_o),
    .found_score_o(found_score_o),
    .found_depth_o(found_depth_o),
    .found_eval_o (found_eval_o),
    .found_move_o (found_move_o),
    .found_kind_o (found_kind_o),
    .found_age_o  (found_age_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic item_t make_word(op_e op, logic [63:0] key, logic [15:0] depth,
                                      logic [15:0] score, logic [1:0] kind,
                                      logic [15:0] move, logic [15:0] eval);
    item_t w;
    w.op        = op;
    w.key       = key;
    w.depth     = depth;
    w.score     = score;
    w.node_kind = kind;
    w.move      = move;
    w.eval      = eval;
    return w;
  endfunction

  function automatic logic [15:0] extreme16();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // Mostly keys from a small pool so slots collide and probes hit
  function automatic item_t random_word();
    item_t       w;
    int unsigned roll;
    if ($urandom_range(0, 9) == 0) w.key = {$urandom, $urandom};
    else w.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    roll = $urandom_range(0, 99);
    if (roll < 47)      w.op = OP_PROBE;
    else if (roll < 95) w.op = OP_STORE;
    else if (roll < 99) w.op = OP_NEW_SEARCH;
    else                w.op = OP_CLEAR;
    // depths close together so replacement goes both ways
    case ($urandom_range(0, 9))
      0:       w.depth = 16'($urandom);
      1:       w.depth = extreme16();
      default: w.depth = 16'($signed($urandom_range(0, 24)) - 4);
    endcase
    w.score     = ($urandom_range(0, 9) == 0) ? extreme16() : 16'($urandom);
    w.node_kind = 2'($urandom);
    w.move      = ($urandom_range(0, 9) == 0) ? extreme16() : 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    w.eval = EVAL_NONE;
      2:       w.eval = $urandom_range(0, 1) ? INT16_TOP : -INT16_TOP;
      default: w.eval = 16'($urandom);
    endcase
    return w;
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(item_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= w.op;
    key_i       <= w.key;
    depth_i     <= w.depth;
    score_i     <= w.score;
    node_kind_i <= w.node_kind;
    move_i      <= w.move;
    eval_i      <= w.eval;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  // Result side: random stall before each word
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(res_t'({hit_o, written_o, found_score_o, found_depth_o, found_eval_o,
                            found_move_o, found_kind_o, found_age_o}));
    end
  end

  initial begin
    logic [63:0]           k1;
    logic [63:0]           k2;
    logic [INDEX_BITS-1:0] idx_pick [12];
    int                    n;
    int                    k;

    k1 = 64'h5a5a_1234_0000_0155;
    k2 = 64'ha5a5_8765_ffff_fd55;   // same slot as k1, other high bits

    // key pool: a dozen slots, three keys each, plus all-zero and all-one keys
    foreach (idx_pick[i]) idx_pick[i] = INDEX_BITS'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (k = 2; k < KEY_POOL; k++) begin
      key_pool[k] = {$urandom, $urandom};
      key_pool[k][INDEX_BITS-1:0] = idx_pick[k % 12];
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty slot probed with key 0 hits with zero contents; other key misses
    send_word(make_word(OP_PROBE, '0, 16'h1111, 16'h2222, 2'd1, 16'h3333, 16'h4444));
    send_word(make_word(OP_PROBE, k1, '0, '0, '0, '0, '0));
    // depth-preferred replacement within one generation
    send_word(make_word(OP_STORE, k1, 16'd5, 16'd77, 2'd2, 16'h1234, 16'd1234));
    send_word(make_word(OP_PROBE, k1, '0, '0, '0, '0, '0));
    send_word(make_word(OP_STORE, k1, 16'd3, 16'd99, 2'd1, 16'h4321, 16'd100));
    // equal depth replaces; eval none keeps the old eval for the same key
    send_word(make_word(OP_STORE, k1, 16'd5, 16'hff00, 2'd3, 16'h0f0f, EVAL_NONE));
    send_word(make_word(OP_PROBE, k1, '0, '0, '0, '0, '0));
    // other key in the same slot: eval none is stored as none
    send_word(make_word(OP_STORE, k2, 16'd5, 16'h00ff, 2'd0, 16'hf0f0, EVAL_NONE));
    send_word(make_word(OP_PROBE, k2, '0, '0, '0, '0, '0));
    send_word(make_word(OP_PROBE, k1, '0, '0, '0, '0, '0));
    // never-written slot with matching key 0: eval none stored as none
    send_word(make_word(OP_STORE, '0, 16'h8000, 16'h8000, 2'd2, 16'h0000, EVAL_NONE));
    send_word(make_word(OP_PROBE, '0, '0, '0, '0, '0, '0));
    // all-ones key with the top values, then a shallower store refused
    send_word(make_word(OP_STORE, '1, 16'h7fff, 16'h7fff, 2'd3, 16'hffff, INT16_TOP));
    send_word(make_word(OP_PROBE, '1, '0, '0, '0, '0, '0));
    send_word(make_word(OP_STORE, '1, 16'h8000, 16'h8000, 2'd0, 16'h0000, -INT16_TOP));
    // a new search makes the old entry replaceable at any depth
    send_word(make_word(OP_NEW_SEARCH, '1, '1, '1, '1, '1, '1));
    send_word(make_word(OP_STORE, '1, 16'h8000, 16'h8000, 2'd0, 16'h0000, -INT16_TOP));
    send_word(make_word(OP_PROBE, '1, '0, '0, '0, '0, '0));
    // clear wipes the table and restarts the generation
    send_word(make_word(OP_CLEAR, k2, '1, '1, '1, '1, '1));
    send_word(make_word(OP_PROBE, '1, '0, '0, '0, '0, '0));
    send_word(make_word(OP_PROBE, '0, '0, '0, '0, '0, '0));

    // random traffic
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) begin
        // walk the generation through 255 so it wraps past 0
        for (k = 0; k < WRAP_RUN; k++) begin
          send_word(make_word(OP_NEW_SEARCH, {$urandom, $urandom}, 16'($urandom),
                              16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom)));
        end
      end
      send_word(random_word());
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
